// File: sv/assert_macros.svh
// Assertion helpers for the posture alarm checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define SPHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spha check failed");

// Clocked check that also runs through reset.
`define SPHA_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spha reset check failed");

`endif

// File: sv/spha_pkg.sv
`default_nettype none

package spha_pkg;

    localparam int unsigned TILT_W    = 13;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned POSE_W    = 3;
    localparam int unsigned CAUSE_W   = 2;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned MIN_W     = 8;
    localparam int unsigned LIMIT_W   = 14;
    localparam int unsigned CFG_POSES = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 52;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd4;

    localparam logic [12:0] DELTA_RST   = 13'd240;
    localparam logic [2:0]  SAMPLES_RST = 3'd3;
    localparam logic [2:0]  COUNT_MAX   = 3'd7;

    // clear causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MOVED = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_POSE  = 2'd2;

    typedef struct packed {
        logic signed [TILT_W-1:0] tilt;
        logic [TIME_W-1:0]        now_seconds;
        logic                     recalibrate;
    } t_smp;

    typedef struct packed {
        logic [POSE_W-1:0]  posture;
        logic               alarm_active;
        logic               alarm_raised;
        logic               alarm_cleared;
        logic [CAUSE_W-1:0] clear_cause;
        logic [TIME_W-1:0]  held_seconds;
    } t_res;

    // sample after binning, held in the input stage
    typedef struct packed {
        logic signed [TILT_W-1:0] tilt;
        logic [TIME_W-1:0]        now_seconds;
        logic                     recalibrate;
        logic                     bin_hit;
        logic [POSE_W-1:0]        bin_idx;
    } t_stage;

    typedef struct packed {
        logic [47:0] minutes;
        logic [12:0] delta;
        logic [2:0]  samples;
    } t_cfg;

endpackage

`default_nettype wire

// File: sv/spha_smp_if.sv
`default_nettype none

interface spha_smp_if;
    logic          valid;
    logic          ready;
    spha_pkg::t_smp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/spha_res_if.sv
`default_nettype none

interface spha_res_if;
    logic          valid;
    logic          ready;
    spha_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/spha_bin.sv
`default_nettype none

module spha_bin #(
    parameter int unsigned NUM_POSES = 6
) (
    input  wire logic signed [spha_pkg::TILT_W-1:0] i_tilt,
    input  wire logic [51:0]                        i_bounds_lo,
    input  wire logic [38:0]                        i_bounds_hi,
    output logic                                    o_hit,
    output logic [spha_pkg::POSE_W-1:0]             o_idx
);

    localparam int unsigned NB =
        (NUM_POSES < spha_pkg::CFG_POSES) ? NUM_POSES : spha_pkg::CFG_POSES;

    logic signed [spha_pkg::TILT_W-1:0] w_bound [0:spha_pkg::CFG_POSES];

    // bound 0 opens posture 0, bound k closes posture k-1
    assign w_bound[0] = signed'(i_bounds_lo[12:0]);
    assign w_bound[1] = signed'(i_bounds_lo[25:13]);
    assign w_bound[2] = signed'(i_bounds_lo[38:26]);
    assign w_bound[3] = signed'(i_bounds_lo[51:39]);
    assign w_bound[4] = signed'(i_bounds_hi[12:0]);
    assign w_bound[5] = signed'(i_bounds_hi[25:13]);
    assign w_bound[6] = signed'(i_bounds_hi[38:26]);

    // scan from the top down so the lowest matching bin wins
    always_comb begin
        o_hit = 1'b0;
        o_idx = '0;
        for (int i = NB - 1; i >= 0; i--) begin
            if (i == 0) begin
                if (w_bound[0] <= i_tilt && i_tilt <= w_bound[1]) begin
                    o_hit = 1'b1;
                    o_idx = '0;
                end
            end else if (i_tilt <= w_bound[i+1]) begin
                o_hit = 1'b1;
                o_idx = spha_pkg::POSE_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/spha_core.sv
`default_nettype none

module spha_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire spha_pkg::t_stage  i_stage,
    input  wire spha_pkg::t_cfg    i_cfg,
    output spha_pkg::t_res         o_res
);

    logic [spha_pkg::POSE_W-1:0]        r_held, n_held;
    logic [spha_pkg::POSE_W-1:0]        r_cur, n_cur;
    logic [spha_pkg::TIME_W-1:0]        r_start, n_start;
    logic signed [spha_pkg::TILT_W-1:0] r_latch, n_latch;
    logic [spha_pkg::COUNT_W-1:0]       r_moved, n_moved;
    logic                               r_alarm, n_alarm;

    logic [spha_pkg::MIN_W-1:0]   w_min;
    logic [spha_pkg::LIMIT_W-1:0] w_limit;
    logic [spha_pkg::TIME_W-1:0]  w_elapsed;
    logic                         w_timed;
    logic signed [spha_pkg::TILT_W:0] w_diff;
    logic [spha_pkg::TILT_W:0]    w_absdiff;
    logic                         w_moved;
    logic                         w_raised, w_cleared;
    logic [spha_pkg::CAUSE_W-1:0] w_cause;

    // per-posture limit: minutes * 60 as (m << 6) - (m << 2)
    always_comb begin
        w_min = '0;
        for (int i = 0; i < spha_pkg::CFG_POSES; i++) begin
            if (n_cur == spha_pkg::POSE_W'(i)) begin
                w_min = i_cfg.minutes[i*8 +: 8];
            end
        end
        w_limit = {w_min, 6'b0} - {4'b0, w_min, 2'b0};
    end

    assign n_cur     = i_stage.bin_hit ? i_stage.bin_idx : r_cur;
    assign w_elapsed = i_stage.now_seconds - r_start;
    assign w_timed   = (r_held == n_cur) &&
                       (w_elapsed >= {{(spha_pkg::TIME_W-spha_pkg::LIMIT_W){1'b0}}, w_limit});
    assign w_diff    = {r_latch[spha_pkg::TILT_W-1], r_latch}
                     - {i_stage.tilt[spha_pkg::TILT_W-1], i_stage.tilt};
    assign w_absdiff = w_diff[spha_pkg::TILT_W] ? unsigned'(-w_diff) : unsigned'(w_diff);
    assign w_moved   = w_absdiff > {1'b0, i_cfg.delta};

    always_comb begin
        n_held    = r_held;
        n_start   = r_start;
        n_latch   = r_latch;
        n_moved   = r_moved;
        n_alarm   = r_alarm;
        w_raised  = 1'b0;
        w_cleared = 1'b0;
        w_cause   = spha_pkg::CAUSE_NONE;
        if (i_stage.recalibrate) begin
            n_held  = n_cur;
            n_start = i_stage.now_seconds;
            n_moved = '0;
        end else if (w_timed) begin
            if (!r_alarm) begin
                n_latch  = i_stage.tilt;
                n_alarm  = 1'b1;
                w_raised = 1'b1;
            end else if (w_moved) begin
                if (r_moved > i_cfg.samples) begin
                    n_latch   = i_stage.tilt;
                    n_moved   = '0;
                    n_alarm   = 1'b0;
                    n_start   = i_stage.now_seconds;
                    w_cleared = 1'b1;
                    w_cause   = spha_pkg::CAUSE_MOVED;
                end else if (r_moved != spha_pkg::COUNT_MAX) begin
                    n_moved = r_moved + 1'b1;
                end
            end else begin
                n_moved = '0;
            end
        end else if (r_held != n_cur) begin
            if (r_alarm) begin
                n_alarm   = 1'b0;
                n_moved   = '0;
                w_cleared = 1'b1;
                w_cause   = spha_pkg::CAUSE_POSE;
            end
            n_held  = n_cur;
            n_start = i_stage.now_seconds;
        end
    end

    always_comb begin
        o_res.posture       = n_cur;
        o_res.alarm_active  = n_alarm;
        o_res.alarm_raised  = w_raised;
        o_res.alarm_cleared = w_cleared;
        o_res.clear_cause   = w_cause;
        o_res.held_seconds  = i_stage.now_seconds - n_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_cur   <= '0;
            r_start <= '0;
            r_latch <= '0;
            r_moved <= '0;
            r_alarm <= 1'b0;
        end else if (i_fire) begin
            r_held  <= n_held;
            r_cur   <= n_cur;
            r_start <= n_start;
            r_latch <= n_latch;
            r_moved <= n_moved;
            r_alarm <= n_alarm;
        end
    end

endmodule

`default_nettype wire

// File: sv/sleep_posture_hold_alarm.sv
// Sleep posture hold alarm.
// i_smp (sink) takes one tilt beat per cycle while ready is high: tilt in 1/16 degree, the
// seconds count and a recalibrate flag. o_res (source) returns one status
// beat per sample, in order: posture, alarm state, raise/clear flags with
// the clear cause, and seconds held in the current posture.
// Configuration goes in through i_cfg_we / i_cfg_idx / i_cfg_wdata; write it
// only while no sample is in flight.
// Binning sits ahead of the input register; the state update and
// hold/cancel compares sit ahead of the result register.
// Throughput: one sample per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its beat and the
// input register keeps one more sample; ready drops once both are full.
// Reset clears posture, timing, alarm and the valid flags of both pipeline
// registers; the config registers return to all bounds and limits zero,
// cancel delta 240 and cancel sample count 3.
`default_nettype none

module sleep_posture_hold_alarm #(
    parameter int unsigned NUM_POSES = 6
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [spha_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [spha_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    spha_smp_if.sink                                 i_smp,
    spha_res_if.source                               o_res
);

    // configuration registers
    logic [51:0] r_bounds_lo;
    logic [38:0] r_bounds_hi;
    logic [47:0] r_minutes;
    logic [12:0] r_delta;
    logic [2:0]  r_samples;

    // input stage and result stage
    logic             r_s1_valid;
    spha_pkg::t_stage r_s1, n_s1;
    logic             r_out_valid;
    spha_pkg::t_res   r_out;

    logic             w_out_free;
    logic             w_fire;
    logic             w_accept;
    spha_pkg::t_cfg   w_cfg;
    spha_pkg::t_res   w_res;
    logic             w_hit;
    logic [spha_pkg::POSE_W-1:0] w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds_lo <= '0;
            r_bounds_hi <= '0;
            r_minutes   <= '0;
            r_delta     <= spha_pkg::DELTA_RST;
            r_samples   <= spha_pkg::SAMPLES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spha_pkg::REG_BOUNDS_LO: r_bounds_lo <= i_cfg_wdata[51:0];
                spha_pkg::REG_BOUNDS_HI: r_bounds_hi <= i_cfg_wdata[38:0];
                spha_pkg::REG_MINUTES:   r_minutes   <= i_cfg_wdata[47:0];
                spha_pkg::REG_DELTA:     r_delta     <= i_cfg_wdata[12:0];
                spha_pkg::REG_SAMPLES:   r_samples   <= i_cfg_wdata[2:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign w_cfg.minutes = r_minutes;
    assign w_cfg.delta   = r_delta;
    assign w_cfg.samples = r_samples;

    // Handshake: the result register frees when empty or taken, the input
    // stage advances into it, and a new beat enters behind it.
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_fire      = r_s1_valid && w_out_free;
    assign i_smp.ready = !r_s1_valid || w_out_free;
    assign w_accept    = i_smp.valid && i_smp.ready;

    // Bin the tilt on the way in so the stage register holds the bin index.
    spha_bin #(
        .NUM_POSES (NUM_POSES)
    ) u_bin (
        .i_tilt      (i_smp.data.tilt),
        .i_bounds_lo (r_bounds_lo),
        .i_bounds_hi (r_bounds_hi),
        .o_hit       (w_hit),
        .o_idx       (w_idx)
    );

    always_comb begin
        n_s1.tilt        = i_smp.data.tilt;
        n_s1.now_seconds = i_smp.data.now_seconds;
        n_s1.recalibrate = i_smp.data.recalibrate;
        n_s1.bin_hit     = w_hit;
        n_s1.bin_idx     = w_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    // Posture timing and alarm state; commits only when the stage fires.
    spha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_stage (r_s1),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

// File: sv/spha_checker.sv
`default_nettype none
`include "assert_macros.svh"

module spha_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           i_in_ready,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire spha_pkg::t_res i_out_data
);

    // no result beat right after reset
    `SPHA_ASSERT_RST(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid)

    // a stalled result beat stays and holds
    `SPHA_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))

    // cause is set exactly when the alarm clears
    `SPHA_ASSERT(a_cause, i_clk, i_rst_n, i_out_valid |-> (i_out_data.alarm_cleared == (i_out_data.clear_cause != spha_pkg::CAUSE_NONE)))

    // raise leaves the alarm on, clear leaves it off, never both
    `SPHA_ASSERT(a_flags, i_clk, i_rst_n, i_out_valid |-> (!i_out_data.alarm_raised || i_out_data.alarm_active) && (!i_out_data.alarm_cleared || !i_out_data.alarm_active))

    // with both stages full and the input held off, the result beat stays valid
    `SPHA_ASSERT(a_backpressure, i_clk, i_rst_n, i_out_valid && !i_out_ready && !i_in_ready && i_in_valid |=> i_out_valid)

endmodule

bind sleep_posture_hold_alarm spha_checker u_spha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire
